FILE: src/lqrsf_pkg.sv
// Shared types, constants and functions for the LQR attitude state-feedback unit.
// No dependencies; used by every module of the block.
`default_nettype none

package lqrsf_pkg;

  localparam int FIN_COUNT      = 4;
  localparam int STATE_COUNT    = 6;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int GAIN_ENTRIES   = FIN_COUNT * STATE_COUNT;
  localparam int ADDR_W         = $clog2(GAIN_ENTRIES);
  localparam int COL_W          = $clog2(STATE_COUNT);
  localparam int ROW_W          = $clog2(FIN_COUNT);

  localparam int GAIN_W  = 16;
  localparam int ANGLE_W = 15;
  localparam int ERR_W   = ANGLE_W + 1;
  localparam int RATE_W  = 16;
  localparam int X_W     = RATE_W + 3;              // negated rate times 4
  localparam int PROD_W  = GAIN_W + X_W;
  localparam int ACC_W   = PROD_W + 3;              // six products
  localparam int SH_W    = ACC_W - GAIN_FRAC_BITS;
  localparam int LIM_W   = 14;
  localparam int OUT_W   = 15;
  localparam int CFG_W   = 32;
  localparam int PADDR_W = 5;

  localparam logic signed [ERR_W-1:0] HALF_TURN = ERR_W'(11520);
  localparam logic signed [ERR_W-1:0] TURN      = ERR_W'(23040);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GAIN_ENTRIES - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(STATE_COUNT - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(FIN_COUNT - 1);
  localparam logic [LIM_W-1:0]  LIMIT_RESET = LIM_W'(3840);

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_ROLL_WRAP   = 3'd0,
    REG_ROLL_NEG    = 3'd1,
    REG_PITCH_NEG   = 3'd2,
    REG_YAW_NEG     = 3'd3,
    REG_DEFL_LIMIT  = 3'd4
  } reg_index_t;

  typedef logic signed [X_W-1:0]   xval_t;
  typedef xval_t [STATE_COUNT-1:0] xvec_t;
  typedef logic signed [OUT_W-1:0] fin_t;
  typedef fin_t [FIN_COUNT-1:0]    fin_vec_t;

  // One MAC step as issued by the sequencer.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } mac_ctrl_t;

  // Gains loaded at reset, Q4.12, row*6 + column.
  function automatic logic signed [GAIN_W-1:0] gain_reset_value(input logic [ADDR_W-1:0] idx);
    logic signed [GAIN_W-1:0] g;
    case (idx)
      5'd0, 5'd6, 5'd12, 5'd18: g = 16'sd1957;
      5'd1, 5'd19:              g = 16'sd2039;
      5'd7, 5'd13:              g = -16'sd2039;
      5'd2, 5'd8:               g = 16'sd6437;
      5'd14, 5'd20:             g = -16'sd6437;
      5'd3, 5'd9, 5'd15, 5'd21: g = 16'sd642;
      5'd4, 5'd22:              g = 16'sd936;
      5'd10, 5'd16:             g = -16'sd936;
      5'd5, 5'd11:              g = 16'sd1366;
      5'd17, 5'd23:             g = -16'sd1366;
      default:                  g = '0;
    endcase
    return g;
  endfunction

  // Two passes of +-360 degree correction; exactly +-180 stays.
  function automatic logic signed [ERR_W-1:0] wrap_half_turn(input logic signed [ERR_W-1:0] a);
    logic signed [ERR_W-1:0] v;
    v = a;
    for (int k = 0; k < 2; k++) begin
      if (v > HALF_TURN) begin
        v = v - TURN;
      end else if (v < -HALF_TURN) begin
        v = v + TURN;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/lqrsf_gain_store.sv
// Gain table: 24-entry synchronous RAM with registered read.
// Entries never loaded read as the built-in gains (valid bit per entry). Uses lqrsf_pkg.
`default_nettype none

module lqrsf_gain_store (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [lqrsf_pkg::ADDR_W-1:0]        wr_addr,
  input  wire logic signed [lqrsf_pkg::GAIN_W-1:0] wr_data,
  input  wire logic                                rd_en,
  input  wire logic [lqrsf_pkg::ADDR_W-1:0]        rd_addr,
  output logic signed [lqrsf_pkg::GAIN_W-1:0]      rd_gain
);

  logic signed [lqrsf_pkg::GAIN_W-1:0] mem [lqrsf_pkg::GAIN_ENTRIES];
  logic [lqrsf_pkg::GAIN_ENTRIES-1:0]  loaded;
  logic signed [lqrsf_pkg::GAIN_W-1:0] q;
  logic [lqrsf_pkg::ADDR_W-1:0]        rd_addr_q;
  logic                                loaded_q;
  logic                                wr_ok;

  assign wr_ok = wr_en && (wr_addr <= lqrsf_pkg::LAST_ADDR);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q         <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      loaded_q  <= loaded[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (wr_ok) begin
      loaded[wr_addr] <= 1'b1;
    end
  end

  assign rd_gain = loaded_q ? q : lqrsf_pkg::gain_reset_value(rd_addr_q);

endmodule

`default_nettype wire

FILE: src/lqrsf_mac.sv
// Multiply-accumulate datapath: state vector registers, one 16x19 multiplier,
// accumulator, rounding and clamp into the fin deflection registers. Uses lqrsf_pkg.
`default_nettype none

module lqrsf_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                x_load,
  input  wire lqrsf_pkg::xvec_t                    x_in,
  input  wire lqrsf_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [lqrsf_pkg::GAIN_W-1:0] rd_gain,
  input  wire logic [lqrsf_pkg::LIM_W-1:0]         limit,
  output lqrsf_pkg::fin_vec_t                      fins,
  output logic                                     fins_done
);

  lqrsf_pkg::xvec_t      xr;
  lqrsf_pkg::mac_ctrl_t  c1, c2, c3;
  logic signed [lqrsf_pkg::PROD_W-1:0] prod;
  logic signed [lqrsf_pkg::ACC_W-1:0]  acc;
  logic signed [lqrsf_pkg::ACC_W-1:0]  prod_ext;
  logic signed [lqrsf_pkg::ACC_W-1:0]  rnd;
  logic signed [lqrsf_pkg::SH_W-1:0]   sh;
  logic signed [lqrsf_pkg::SH_W-1:0]   lim_pos;
  logic signed [lqrsf_pkg::SH_W-1:0]   clamped;

  // c1: gain read returns; c2: product registered; c3: row sum complete
  always_ff @(posedge clk) begin
    if (rst) begin
      c1        <= '0;
      c2        <= '0;
      c3        <= '0;
      fins_done <= 1'b0;
    end else begin
      c1        <= ctrl;
      c2        <= c1;
      c3        <= '{valid: c2.valid && c2.last, first: c2.first, last: c2.last,
                     col: c2.col, row: c2.row};
      fins_done <= c3.valid && (c3.row == lqrsf_pkg::LAST_ROW);
    end
  end

  always_ff @(posedge clk) begin
    if (x_load) begin
      xr <= x_in;
    end
    if (c1.valid) begin
      prod <= lqrsf_pkg::PROD_W'($signed(rd_gain) * $signed(xr[c1.col]));
    end
    if (c2.valid) begin
      acc <= c2.first ? -prod_ext : acc - prod_ext;
    end
    if (c3.valid) begin
      fins[c3.row] <= clamped[lqrsf_pkg::OUT_W-1:0];
    end
  end

  assign prod_ext = {{(lqrsf_pkg::ACC_W - lqrsf_pkg::PROD_W){prod[lqrsf_pkg::PROD_W-1]}}, prod};

  // round half up, then clamp to +-limit
  always_comb begin
    rnd     = acc + lqrsf_pkg::ROUND_HALF;
    sh      = rnd[lqrsf_pkg::ACC_W-1:lqrsf_pkg::GAIN_FRAC_BITS];
    lim_pos = $signed({{(lqrsf_pkg::SH_W - lqrsf_pkg::LIM_W){1'b0}}, limit});
    if (sh > lim_pos) begin
      clamped = lim_pos;
    end else if (sh < -lim_pos) begin
      clamped = -lim_pos;
    end else begin
      clamped = sh;
    end
  end

endmodule

`default_nettype wire

FILE: src/lqr_attitude_state_feedback_unit.sv
// Top level of the LQR attitude state-feedback unit: stream ports, APB registers,
// MAC sequencer and result register. Uses lqrsf_pkg, lqrsf_gain_store, lqrsf_mac.
`default_nettype none

// A load transaction (tuser = 1) writes one gain and leaves the input ready;
// an index above 23 is dropped. A compute transaction (tuser = 0) walks the 4x6
// gain table through one multiplier, one gain per cycle from the gain RAM. After
// the last read the product is registered, accumulated, then rounded and clamped
// into the fin registers; the done flag is registered, and the axis commands are
// then formed into the output register. s_axis_tready is low during that walk and
// returns the cycle after the result is loaded, so a compute item is not accepted
// while the previous one is walking; the next item is accepted even if the
// downstream side has not taken the result yet, and a following result waits at
// the end of its walk until the output register is free. Gains come up as the
// built-in LQR set after reset with no clearing pass.
module lqr_attitude_state_feedback_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // gain_index[4:0], gain_value[20:5], roll_now[35:21], roll_goal[50:36],
  // pitch_now[65:51], pitch_goal[80:66], yaw_now[95:81], yaw_goal[110:96],
  // roll_rate[126:111], pitch_rate[142:127], yaw_rate[158:143], zero[159]
  input  wire logic [159:0] s_axis_tdata,
  // op[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // fin_upper_right[14:0], fin_upper_left[29:15], fin_lower_left[44:30],
  // fin_lower_right[59:45], roll_command[74:60], pitch_command[89:75],
  // yaw_command[104:90], zero[111:105]
  output logic [111:0]      m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [lqrsf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lqrsf_pkg::CFG_W-1:0]   pwdata,
  output logic [lqrsf_pkg::CFG_W-1:0]        prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  state_t state;

  logic                              roll_wrap_enable;
  logic                              roll_rate_negate;
  logic                              pitch_rate_negate;
  logic                              yaw_rate_negate;
  logic [lqrsf_pkg::LIM_W-1:0]       deflection_limit;

  logic [lqrsf_pkg::ADDR_W-1:0]      addr;
  logic [lqrsf_pkg::COL_W-1:0]       col;
  logic [lqrsf_pkg::ROW_W-1:0]       row;

  logic [lqrsf_pkg::ADDR_W-1:0]        gain_index;
  logic signed [lqrsf_pkg::GAIN_W-1:0] gain_value;
  logic signed [lqrsf_pkg::ANGLE_W-1:0] roll_now, roll_goal, pitch_now, pitch_goal;
  logic signed [lqrsf_pkg::ANGLE_W-1:0] yaw_now, yaw_goal;
  logic signed [lqrsf_pkg::RATE_W-1:0]  roll_rate, pitch_rate, yaw_rate;

  logic                 in_accept;
  logic                 load_we;
  logic                 cfg_we;
  logic                 out_free;
  lqrsf_pkg::xvec_t     x_in;
  lqrsf_pkg::mac_ctrl_t ctrl;
  lqrsf_pkg::fin_vec_t  fins;
  logic                 fins_done;
  logic signed [lqrsf_pkg::GAIN_W-1:0] rd_gain;
  logic signed [lqrsf_pkg::OUT_W-1:0]  roll_command, pitch_command, yaw_command;

  assign gain_index = s_axis_tdata[4:0];
  assign gain_value = s_axis_tdata[20:5];
  assign roll_now   = s_axis_tdata[35:21];
  assign roll_goal  = s_axis_tdata[50:36];
  assign pitch_now  = s_axis_tdata[65:51];
  assign pitch_goal = s_axis_tdata[80:66];
  assign yaw_now    = s_axis_tdata[95:81];
  assign yaw_goal   = s_axis_tdata[110:96];
  assign roll_rate  = s_axis_tdata[126:111];
  assign pitch_rate = s_axis_tdata[142:127];
  assign yaw_rate   = s_axis_tdata[158:143];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_accept && (s_axis_tuser == lqrsf_pkg::OP_LOAD);
  assign cfg_we        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Rate term: optional negate, then x4 to reach 1/64 degree per second.
  function automatic lqrsf_pkg::xval_t rate_term(
    input logic signed [lqrsf_pkg::RATE_W-1:0] r,
    input logic                                neg
  );
    logic signed [lqrsf_pkg::RATE_W:0] r_ext;
    r_ext = {r[lqrsf_pkg::RATE_W-1], r};
    if (neg) begin
      r_ext = -r_ext;
    end
    return {r_ext, 2'b00};
  endfunction

  function automatic lqrsf_pkg::xval_t err_term(input logic signed [lqrsf_pkg::ERR_W-1:0] e);
    return {{(lqrsf_pkg::X_W - lqrsf_pkg::ERR_W){e[lqrsf_pkg::ERR_W-1]}}, e};
  endfunction

  // (sum + 2) >> 2, floor
  function automatic logic signed [lqrsf_pkg::OUT_W-1:0] quarter(
    input logic signed [lqrsf_pkg::OUT_W+2:0] s
  );
    logic signed [lqrsf_pkg::OUT_W+2:0] t;
    t = s + 18'sd2;
    return t[lqrsf_pkg::OUT_W+1:2];
  endfunction

  always_comb begin
    logic signed [lqrsf_pkg::ERR_W-1:0] roll_diff;
    logic signed [lqrsf_pkg::ERR_W-1:0] pitch_diff;
    logic signed [lqrsf_pkg::ERR_W-1:0] yaw_diff;
    roll_diff  = {roll_now[lqrsf_pkg::ANGLE_W-1], roll_now}
               - {roll_goal[lqrsf_pkg::ANGLE_W-1], roll_goal};
    pitch_diff = {pitch_now[lqrsf_pkg::ANGLE_W-1], pitch_now}
               - {pitch_goal[lqrsf_pkg::ANGLE_W-1], pitch_goal};
    yaw_diff   = {yaw_now[lqrsf_pkg::ANGLE_W-1], yaw_now}
               - {yaw_goal[lqrsf_pkg::ANGLE_W-1], yaw_goal};
    if (roll_wrap_enable) begin
      roll_diff = lqrsf_pkg::wrap_half_turn(roll_diff);
    end
    yaw_diff = lqrsf_pkg::wrap_half_turn(yaw_diff);
    x_in[0] = err_term(roll_diff);
    x_in[1] = err_term(pitch_diff);
    x_in[2] = err_term(yaw_diff);
    x_in[3] = rate_term(roll_rate, roll_rate_negate);
    x_in[4] = rate_term(pitch_rate, pitch_rate_negate);
    x_in[5] = rate_term(yaw_rate, yaw_rate_negate);
  end

  always_comb begin
    logic signed [lqrsf_pkg::OUT_W+2:0] d0, d1, d2, d3;
    d0 = {{3{fins[0][lqrsf_pkg::OUT_W-1]}}, fins[0]};
    d1 = {{3{fins[1][lqrsf_pkg::OUT_W-1]}}, fins[1]};
    d2 = {{3{fins[2][lqrsf_pkg::OUT_W-1]}}, fins[2]};
    d3 = {{3{fins[3][lqrsf_pkg::OUT_W-1]}}, fins[3]};
    roll_command  = quarter(d0 + d1 + d2 + d3);
    pitch_command = quarter(d0 - d1 - d2 + d3);
    yaw_command   = quarter(d0 + d1 - d2 - d3);
  end

  always_comb begin
    ctrl.valid = (state == ST_RUN);
    ctrl.first = (col == '0);
    ctrl.last  = (col == lqrsf_pkg::LAST_COL);
    ctrl.col   = col;
    ctrl.row   = row;
  end

  always_comb begin
    unique case (lqrsf_pkg::reg_index_t'(paddr[4:2]))
      lqrsf_pkg::REG_ROLL_WRAP:  prdata = {31'd0, roll_wrap_enable};
      lqrsf_pkg::REG_ROLL_NEG:   prdata = {31'd0, roll_rate_negate};
      lqrsf_pkg::REG_PITCH_NEG:  prdata = {31'd0, pitch_rate_negate};
      lqrsf_pkg::REG_YAW_NEG:    prdata = {31'd0, yaw_rate_negate};
      lqrsf_pkg::REG_DEFL_LIMIT: prdata = {18'd0, deflection_limit};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      addr              <= '0;
      col               <= '0;
      row               <= '0;
      m_axis_tvalid     <= 1'b0;
      roll_wrap_enable  <= 1'b0;
      roll_rate_negate  <= 1'b0;
      pitch_rate_negate <= 1'b0;
      yaw_rate_negate   <= 1'b0;
      deflection_limit  <= lqrsf_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (lqrsf_pkg::reg_index_t'(paddr[4:2]))
          lqrsf_pkg::REG_ROLL_WRAP:  roll_wrap_enable  <= pwdata[0];
          lqrsf_pkg::REG_ROLL_NEG:   roll_rate_negate  <= pwdata[0];
          lqrsf_pkg::REG_PITCH_NEG:  pitch_rate_negate <= pwdata[0];
          lqrsf_pkg::REG_YAW_NEG:    yaw_rate_negate   <= pwdata[0];
          lqrsf_pkg::REG_DEFL_LIMIT: deflection_limit  <= pwdata[lqrsf_pkg::LIM_W-1:0];
          default: ;
        endcase
      end

      // a new result replaces the one being taken in the same cycle
      if ((state == ST_EMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept && (s_axis_tuser == lqrsf_pkg::OP_COMPUTE)) begin
            state <= ST_RUN;
            addr  <= '0;
            col   <= '0;
            row   <= '0;
          end
        end
        ST_RUN: begin
          addr <= addr + 1'b1;
          if (col == lqrsf_pkg::LAST_COL) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          if (addr == lqrsf_pkg::LAST_ADDR) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (fins_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_axis_tdata  <= {7'd0, yaw_command, pitch_command, roll_command,
                              fins[3], fins[2], fins[1], fins[0]};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lqrsf_gain_store u_gain_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load_we),
    .wr_addr (gain_index),
    .wr_data (gain_value),
    .rd_en   (ctrl.valid),
    .rd_addr (addr),
    .rd_gain (rd_gain)
  );

  lqrsf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .x_load    (in_accept),
    .x_in      (x_in),
    .ctrl      (ctrl),
    .rd_gain   (rd_gain),
    .limit     (deflection_limit),
    .fins      (fins),
    .fins_done (fins_done)
  );

endmodule

`default_nettype wire

FILE: src/lqrsf_checker.sv
// Port-level checker for lqr_attitude_state_feedback_unit, bound to the top level.
// Uses lqrsf_pkg for the op codes.
`default_nettype none

module lqrsf_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a compute transaction occupies the MAC, so input must back off
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == lqrsf_pkg::OP_COMPUTE)
    |=> !s_axis_tready)
    else $error("input ready during gain walk");

  // a gain load finishes in the accepting cycle
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == lqrsf_pkg::OP_LOAD)
    |=> s_axis_tready)
    else $error("gain load stalled input");

  // clamp keeps |d| within 16383, so the most negative code never shows
  a_fin_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[14:0] != 15'h4000))
    else $error("fin deflection outside clamp range");

endmodule

bind lqr_attitude_state_feedback_unit lqrsf_checker u_lqrsf_checker (.*);

`default_nettype wire
